/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/smacd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smacd_pkg;

    localparam int NUM_SYMBOLS = 16;
    localparam int MAX_SLOW    = 64;
    localparam int PRICE_BITS  = 32;

    localparam int SYM_W      = $clog2(NUM_SYMBOLS);
    localparam int HIST_DEPTH = MAX_SLOW + 1;
    localparam int SLOT_W     = $clog2(HIST_DEPTH);
    localparam int MEM_AW     = SYM_W + SLOT_W;
    localparam int FAST_W     = 6;
    localparam int SLOW_W     = 7;
    localparam int SUM_W      = PRICE_BITS + SLOT_W;
    localparam int PROD_W     = SUM_W + SLOW_W;

    localparam int IN_TDATA_W  = ((SYM_W + PRICE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SYM_W + 1 + 7) / 8) * 8;

    localparam logic [FAST_W-1:0] FAST_RESET = FAST_W'(10);
    localparam logic [SLOW_W-1:0] SLOW_RESET = SLOW_W'(30);

    // Configuration register indexes
    localparam logic CFG_FAST_WINDOW = 1'b0;
    localparam logic CFG_SLOW_WINDOW = 1'b1;

    // Signal directions
    localparam logic DIR_LONG = 1'b0;
    localparam logic DIR_EXIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_MUL,
        ST_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;   // latch input word
        logic write;    // store price, bump fill count, clear sums
        logic rd_en;    // read history entry at current age
        logic mul;      // form cross products
        logic decide;   // compare, update position, load output
    } ctrl_cmd_t;

    typedef struct packed {
        logic calc_ok;  // windows valid and history long enough
        logic age_last; // current read age is the slow window
        logic out_free; // output register can take a word
    } ctrl_stat_t;

endpackage

`default_nettype wire

/* rtl/core/sma_crossover_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Moving average crossover detector, up to 16 instruments.
// Input stream: one bar per word, symbol index and 16.16 closing price.
// Output stream: one word per crossing, symbol and direction
// (0 = long entry on golden cross, 1 = exit on death cross).
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 fast window,
// index 1 slow window; write only while no bar is in flight.
// Sequencing: a bar that cannot raise a signal (bad windows or short
// history) is stored and the block is ready again. A checked bar is
// stored, then a sweep reads slow_window + 1 history entries through the
// single memory read port, followed by drain, multiply and decide steps.
// A signal is registered in the decide step and then shows on
// m_axis_tvalid.
// Reset clears fill counts and positions (all symbols flat) and loads
// windows 10 and 30; history memory needs no clearing.
// A stalled receiver holds the output word; the next bar is still taken,
// and its result waits in the decision step until the output frees up.
module sma_crossover_detector (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [3:0] symbol_index, [35:4] close_price, [39:36] zero
    input  wire logic [smacd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [3:0] signal_symbol, [4] direction, [7:5] zero
    output logic [smacd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [smacd_pkg::SLOW_W-1:0]         cfg_wdata
);

    smacd_pkg::ctrl_cmd_t  cmd;
    smacd_pkg::ctrl_stat_t stat;

    logic [smacd_pkg::SYM_W-1:0] out_symbol;
    logic                        out_direction;

    smacd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    smacd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_symbol     (s_axis_tdata[smacd_pkg::SYM_W-1:0]),
        .in_price      (s_axis_tdata[smacd_pkg::SYM_W +: smacd_pkg::PRICE_BITS]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_symbol    (out_symbol),
        .out_direction (out_direction)
    );

    assign m_axis_tdata = {(smacd_pkg::OUT_TDATA_W - smacd_pkg::SYM_W - 1)'(0),
                           out_direction, out_symbol};

endmodule

`default_nettype wire

/* rtl/core/smacd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smacd_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire smacd_pkg::ctrl_stat_t stat,
    output smacd_pkg::ctrl_cmd_t       cmd
);

    smacd_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smacd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smacd_pkg::ST_IDLE: begin
                if (s_axis_tvalid) state_next = smacd_pkg::ST_WRITE;
            end
            smacd_pkg::ST_WRITE: begin
                state_next = stat.calc_ok ? smacd_pkg::ST_READ : smacd_pkg::ST_IDLE;
            end
            smacd_pkg::ST_READ: begin
                if (stat.age_last) state_next = smacd_pkg::ST_DRAIN;
            end
            smacd_pkg::ST_DRAIN:  state_next = smacd_pkg::ST_MUL;
            smacd_pkg::ST_MUL:    state_next = smacd_pkg::ST_DECIDE;
            smacd_pkg::ST_DECIDE: begin
                if (stat.out_free) state_next = smacd_pkg::ST_IDLE;
            end
            default: state_next = smacd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            smacd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.accept    = s_axis_tvalid;
            end
            smacd_pkg::ST_WRITE:  cmd.write  = 1'b1;
            smacd_pkg::ST_READ:   cmd.rd_en  = 1'b1;
            smacd_pkg::ST_MUL:    cmd.mul    = 1'b1;
            smacd_pkg::ST_DECIDE: cmd.decide = stat.out_free;
            default: ;
        endcase
    end

    // Reads only happen for items that qualify for a signal check
    `ASSERT_NEXT(a_read_after_ok, aclk, aresetn, cmd.write && !stat.calc_ok, !cmd.rd_en)
    // Read sweep ends in the drain cycle
    `ASSERT_NEXT(a_drain_after_last, aclk, aresetn, cmd.rd_en && stat.age_last, state_reg == smacd_pkg::ST_DRAIN)

endmodule

`default_nettype wire

/* rtl/core/smacd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smacd_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [smacd_pkg::SYM_W-1:0]          in_symbol,
    input  wire logic [smacd_pkg::PRICE_BITS-1:0]     in_price,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [smacd_pkg::SLOW_W-1:0]         cfg_wdata,
    input  wire smacd_pkg::ctrl_cmd_t                 cmd,
    output smacd_pkg::ctrl_stat_t                     stat,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [smacd_pkg::SYM_W-1:0]               out_symbol,
    output logic                                      out_direction
);

    localparam int SW = smacd_pkg::SLOT_W;

    logic [smacd_pkg::FAST_W-1:0]     fast_reg;
    logic [smacd_pkg::SLOW_W-1:0]     slow_reg;
    logic [smacd_pkg::SYM_W-1:0]      sym_reg;
    logic [smacd_pkg::PRICE_BITS-1:0] price_reg;

    logic [SW-1:0] head_reg [smacd_pkg::NUM_SYMBOLS];
    logic [SW-1:0] fill_reg [smacd_pkg::NUM_SYMBOLS];
    logic          long_reg [smacd_pkg::NUM_SYMBOLS];

    logic [smacd_pkg::PRICE_BITS-1:0] mem [2**smacd_pkg::MEM_AW];
    logic [smacd_pkg::PRICE_BITS-1:0] rd_data_reg;

    logic [SW-1:0] age_reg;
    logic [SW-1:0] acc_age_reg;
    logic          acc_vld_reg;

    logic [smacd_pkg::SUM_W-1:0] cur_f_reg, prev_f_reg, cur_s_reg, prev_s_reg;
    logic [smacd_pkg::PROD_W-1:0] cur_fn_reg, cur_sf_reg, prev_fn_reg, prev_sf_reg;

    logic                        out_valid_reg;
    logic [smacd_pkg::SYM_W-1:0] out_symbol_reg;
    logic                        out_dir_reg;

    logic [SW-1:0] head_cur, head_next;
    logic [SW-1:0] fill_cur, fill_next;
    logic [SW:0]   rd_slot_wide;
    logic [SW-1:0] rd_slot;
    logic          win_ok;
    logic [SW-1:0] fast_ext;
    logic          prev_le, prev_ge, cur_gt, cur_lt;
    logic          go_long, go_exit;

    assign head_cur  = head_reg[sym_reg];
    assign fill_cur  = fill_reg[sym_reg];
    assign head_next = (head_cur == SW'(smacd_pkg::HIST_DEPTH - 1)) ? '0 : head_cur + 1'b1;
    assign fill_next = (fill_cur < SW'(smacd_pkg::HIST_DEPTH)) ? fill_cur + 1'b1 : fill_cur;
    assign fast_ext  = SW'(fast_reg);

    assign win_ok = (fast_reg != '0) && (fast_ext < slow_reg)
                    && (slow_reg <= SW'(smacd_pkg::MAX_SLOW));

    // Status back to the controller
    always_comb begin
        stat.calc_ok  = win_ok && ({1'b0, fill_next} >= ({1'b0, slow_reg} + 1'b1));
        stat.age_last = (age_reg == slow_reg);
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg <= smacd_pkg::FAST_RESET;
            slow_reg <= smacd_pkg::SLOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                smacd_pkg::CFG_FAST_WINDOW: fast_reg <= cfg_wdata[smacd_pkg::FAST_W-1:0];
                smacd_pkg::CFG_SLOW_WINDOW: slow_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input word latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg   <= '0;
            price_reg <= '0;
        end else if (cmd.accept) begin
            sym_reg   <= in_symbol;
            price_reg <= in_price;
        end
    end

    // Per-symbol head pointer, fill count and position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < smacd_pkg::NUM_SYMBOLS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
                long_reg[i] <= 1'b0;
            end
        end else begin
            if (cmd.write) begin
                head_reg[sym_reg] <= head_next;
                fill_reg[sym_reg] <= fill_next;
            end
            if (cmd.decide && go_long) long_reg[sym_reg] <= 1'b1;
            if (cmd.decide && go_exit) long_reg[sym_reg] <= 1'b0;
        end
    end

    // Slot of the entry at age_reg, counting back from the newest
    always_comb begin
        if (head_cur >= age_reg) begin
            rd_slot_wide = {1'b0, head_cur} - {1'b0, age_reg};
        end else begin
            rd_slot_wide = {1'b0, head_cur} + (SW+1)'(smacd_pkg::HIST_DEPTH) - {1'b0, age_reg};
        end
        rd_slot = rd_slot_wide[SW-1:0];
    end

    // Price history memory, one ring per symbol
    always_ff @(posedge aclk) begin
        if (cmd.write) mem[{sym_reg, head_next}] <= price_reg;
        if (cmd.rd_en) rd_data_reg <= mem[{sym_reg, rd_slot}];
    end

    // Age sweep and read pipeline tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg     <= '0;
            acc_vld_reg <= 1'b0;
        end else begin
            acc_vld_reg <= cmd.rd_en;
            if (cmd.write) begin
                age_reg <= '0;
            end else if (cmd.rd_en) begin
                age_reg <= age_reg + 1'b1;
            end
        end
        acc_age_reg <= age_reg;
    end

    // Window sums: current windows start at age 0, previous at age 1
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            cur_f_reg  <= '0;
            prev_f_reg <= '0;
            cur_s_reg  <= '0;
            prev_s_reg <= '0;
        end else if (acc_vld_reg) begin
            if (acc_age_reg < fast_ext)
                cur_f_reg <= cur_f_reg + smacd_pkg::SUM_W'(rd_data_reg);
            if ((acc_age_reg != '0) && (acc_age_reg <= fast_ext))
                prev_f_reg <= prev_f_reg + smacd_pkg::SUM_W'(rd_data_reg);
            if (acc_age_reg < slow_reg)
                cur_s_reg <= cur_s_reg + smacd_pkg::SUM_W'(rd_data_reg);
            if (acc_age_reg != '0)
                prev_s_reg <= prev_s_reg + smacd_pkg::SUM_W'(rd_data_reg);
        end
    end

    // Cross products: fast sum times slow period against slow sum times fast period
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            cur_fn_reg  <= {smacd_pkg::SLOW_W'(0), cur_f_reg} * slow_reg;
            prev_fn_reg <= {smacd_pkg::SLOW_W'(0), prev_f_reg} * slow_reg;
            cur_sf_reg  <= {smacd_pkg::SLOW_W'(0), cur_s_reg} * fast_reg;
            prev_sf_reg <= {smacd_pkg::SLOW_W'(0), prev_s_reg} * fast_reg;
        end
    end

    // Crossing decision
    always_comb begin
        prev_le = prev_fn_reg <= prev_sf_reg;
        prev_ge = prev_fn_reg >= prev_sf_reg;
        cur_gt  = cur_fn_reg > cur_sf_reg;
        cur_lt  = cur_fn_reg < cur_sf_reg;
        go_long = prev_le && cur_gt && !long_reg[sym_reg];
        go_exit = prev_ge && cur_lt && long_reg[sym_reg];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.decide && (go_long || go_exit)) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.decide && (go_long || go_exit)) begin
            out_symbol_reg <= sym_reg;
            out_dir_reg    <= go_long ? smacd_pkg::DIR_LONG : smacd_pkg::DIR_EXIT;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_symbol    = out_symbol_reg;
    assign out_direction = out_dir_reg;

    // Fill count saturates at the history depth
    `ASSERT_ALWAYS(a_fill_sat, aclk, aresetn, fill_cur <= SW'(smacd_pkg::HIST_DEPTH))
    // A long entry leaves the symbol long
    `ASSERT_NEXT(a_long_set, aclk, aresetn, cmd.decide && go_long, long_reg[sym_reg])
    // Entry and exit never both qualify
    `ASSERT_ALWAYS(a_one_dir, aclk, aresetn, !(go_long && go_exit))

endmodule

`default_nettype wire

/* tb/sma_crossover_detector_tb.sv */
`timescale 1ns / 1ps

module sma_crossover_detector_tb;

    localparam int SETTLE_CYCLES = smacd_pkg::MAX_SLOW + 16;

    typedef struct {
        logic [smacd_pkg::SYM_W-1:0] sym;
        logic                        dir;
    } crossover_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [smacd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [smacd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              cfg_we;
    logic                              cfg_index;
    logic [smacd_pkg::SLOW_W-1:0]      cfg_wdata;

    // Predictor state: per-symbol price history (newest first), fill, position
    logic [smacd_pkg::PRICE_BITS-1:0] price_hist [smacd_pkg::NUM_SYMBOLS][smacd_pkg::HIST_DEPTH];
    int                               hist_fill [smacd_pkg::NUM_SYMBOLS];
    bit                               is_long [smacd_pkg::NUM_SYMBOLS];
    logic [smacd_pkg::FAST_W-1:0]     fast_w;
    logic [smacd_pkg::SLOW_W-1:0]     slow_w;

    crossover_t pending_signals[$];

    // Random walk per symbol
    logic [smacd_pkg::PRICE_BITS-1:0] walk_price [smacd_pkg::NUM_SYMBOLS];
    int                               walk_left [smacd_pkg::NUM_SYMBOLS];
    bit                               walk_up [smacd_pkg::NUM_SYMBOLS];

    int error_count       = 0;
    int bars_taken        = 0;
    int signals_predicted = 0;
    int signals_seen      = 0;
    int entries_seen      = 0;
    int exits_seen        = 0;
    int settings_used     = 0;
    int hold_request      = 0;
    bit rx_steady         = 1'b0;
    bit tx_steady         = 1'b0;

    sma_crossover_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void clear_predictor();
        for (int s = 0; s < smacd_pkg::NUM_SYMBOLS; s++) begin
            hist_fill[s] = 0;
            is_long[s]   = 1'b0;
            for (int k = 0; k < smacd_pkg::HIST_DEPTH; k++)
                price_hist[s][k] = '0;
        end
        fast_w = smacd_pkg::FAST_RESET;
        slow_w = smacd_pkg::SLOW_RESET;
    endfunction

    function automatic logic [63:0] window_total(int sym, int first, int len);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < len; i++)
            if (first + i < smacd_pkg::HIST_DEPTH)
                acc += 64'(price_hist[sym][first + i]);
        return acc;
    endfunction

    // Sign of fast_avg - slow_avg, by cross-multiplying the sums
    function automatic int avg_order(logic [63:0] fast_sum, logic [63:0] slow_sum);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = fast_sum * 64'(slow_w);
        rhs = slow_sum * 64'(fast_w);
        if (lhs > rhs) return 1;
        if (lhs < rhs) return -1;
        return 0;
    endfunction

    function automatic void predict_bar(input logic [smacd_pkg::SYM_W-1:0] sym,
                                        input logic [smacd_pkg::PRICE_BITS-1:0] price,
                                        output bit fired, output logic dir);
        int prev_ord;
        int curr_ord;
        int f;
        int n;
        fired = 1'b0;
        dir   = smacd_pkg::DIR_LONG;
        f     = int'(fast_w);
        n     = int'(slow_w);
        for (int k = smacd_pkg::HIST_DEPTH - 1; k > 0; k--)
            price_hist[sym][k] = price_hist[sym][k-1];
        price_hist[sym][0] = price;
        if (hist_fill[sym] < smacd_pkg::HIST_DEPTH) hist_fill[sym]++;

        if (f == 0 || f >= n || n > smacd_pkg::MAX_SLOW) return;
        if (hist_fill[sym] < n + 1) return;

        prev_ord = avg_order(window_total(sym, 1, f), window_total(sym, 1, n));
        curr_ord = avg_order(window_total(sym, 0, f), window_total(sym, 0, n));

        if (prev_ord <= 0 && curr_ord > 0 && !is_long[sym]) begin
            is_long[sym] = 1'b1;
            fired = 1'b1;
            dir   = smacd_pkg::DIR_LONG;
        end else if (prev_ord >= 0 && curr_ord < 0 && is_long[sym]) begin
            is_long[sym] = 1'b0;
            fired = 1'b1;
            dir   = smacd_pkg::DIR_EXIT;
        end
    endfunction

    // ---------------------------------------------------------------
    // Monitor: config writes, accepted bars, result words
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        crossover_t sig;
        crossover_t want;
        bit         fired;
        logic       dir;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == smacd_pkg::CFG_FAST_WINDOW)
                    fast_w = cfg_wdata[smacd_pkg::FAST_W-1:0];
                else
                    slow_w = cfg_wdata;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                bars_taken++;
                predict_bar(s_axis_tdata[smacd_pkg::SYM_W-1:0],
                            s_axis_tdata[smacd_pkg::SYM_W +: smacd_pkg::PRICE_BITS],
                            fired, dir);
                if (fired) begin
                    sig.sym = s_axis_tdata[smacd_pkg::SYM_W-1:0];
                    sig.dir = dir;
                    pending_signals.insert(pending_signals.size(), sig);
                    signals_predicted++;
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                signals_seen++;
                if (m_axis_tdata[smacd_pkg::SYM_W] == smacd_pkg::DIR_LONG) entries_seen++;
                else exits_seen++;
                if (pending_signals.size() == 0) begin
                    error_count++;
                    $display("%0t: expected no word, got symbol %0d direction %0d",
                             $time, m_axis_tdata[smacd_pkg::SYM_W-1:0],
                             m_axis_tdata[smacd_pkg::SYM_W]);
                end else begin
                    want = pending_signals[0];
                    pending_signals.delete(0);
                    if (m_axis_tdata[smacd_pkg::SYM_W-1:0] !== want.sym ||
                        m_axis_tdata[smacd_pkg::SYM_W] !== want.dir ||
                        m_axis_tdata[smacd_pkg::OUT_TDATA_W-1:smacd_pkg::SYM_W+1] !== '0) begin
                        error_count++;
                        $display("%0t: expected symbol %0d direction %0d, got %h",
                                 $time, want.sym, want.dir, m_axis_tdata);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus long hold-offs on request
    // ---------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        int r;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (!rx_steady) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) stall_left = $urandom_range(1, 3);
                    else if (r < 23) stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender helpers (entered and left at a falling edge)
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_bar(input int sym, input logic [smacd_pkg::PRICE_BITS-1:0] price);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  = smacd_pkg::IN_TDATA_W'({price, smacd_pkg::SYM_W'(sym)});
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Pause until every predicted word has come out
    task automatic wait_results();
        s_axis_tvalid = 1'b0;
        while (pending_signals.size() != 0) @(negedge aclk);
    endtask

    // Also let a bar with no result finish its sweep
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_windows(input int f, input int n);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_index = smacd_pkg::CFG_FAST_WINDOW;
        cfg_wdata = smacd_pkg::SLOW_W'(f);
        @(negedge aclk);
        cfg_index = smacd_pkg::CFG_SLOW_WINDOW;
        cfg_wdata = smacd_pkg::SLOW_W'(n);
        @(negedge aclk);
        cfg_we    = 1'b0;
        settings_used++;
    endtask

    // One step of a trending random walk, with occasional counter moves
    task automatic send_walk_bar(input int sym);
        int                               mag;
        logic [smacd_pkg::PRICE_BITS-1:0] step;
        logic [smacd_pkg::PRICE_BITS-1:0] p;
        if (walk_left[sym] == 0) begin
            walk_up[sym]   = 1'($urandom_range(0, 1));
            walk_left[sym] = $urandom_range(2, 2 * int'(slow_w) + 4);
        end
        walk_left[sym]--;
        mag  = $urandom_range(0, 24);
        step = $urandom_range(0, 1 << mag);
        p    = walk_price[sym];
        if (walk_up[sym] ^ ($urandom_range(0, 9) == 0))
            p = (p > '1 - step) ? '1 : p + step;
        else
            p = (p < step) ? '0 : p - step;
        walk_price[sym] = p;
        send_bar(sym, p);
    endtask

    // Mostly walk bars on the active symbols, some noise on any symbol
    task automatic send_mixed_bar(input int base_sym, input int active);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_bar(int'($urandom_range(0, smacd_pkg::NUM_SYMBOLS - 1)), $urandom());
        else if (r < 10)
            send_bar(int'($urandom_range(0, smacd_pkg::NUM_SYMBOLS - 1)),
                     $urandom_range(0, 1) ? '1 : '0);
        else
            send_walk_bar(int'((base_sym + $urandom_range(0, active - 1))
                               % smacd_pkg::NUM_SYMBOLS));
        if ($urandom_range(0, 99) < 2) wait_results();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Windows as left by reset (10/30), never written yet
    task automatic test_default_windows();
        for (int i = 0; i < 160; i++) begin
            if (i % 40 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            send_mixed_bar(0, 3);
        end
    endtask

    // Smallest windows: price extremes, ties, entries, exits, cross while long
    task automatic test_minimal_windows();
        logic [smacd_pkg::PRICE_BITS-1:0] seq [8];
        seq = '{'1, '1, '0, '1, '1, '0, '0, 5};
        set_windows(1, 2);
        foreach (seq[i]) send_bar(smacd_pkg::NUM_SYMBOLS - 1, seq[i]);
        repeat (3) send_bar(0, '0);
    endtask

    // Fast of zero, fast not below slow, slow beyond the history: no signals
    task automatic test_invalid_windows();
        set_windows(0, 2);
        send_bar(3, '1);
        send_bar(3, '0);
        send_bar(3, '1);
        set_windows(4, 4);
        send_bar(smacd_pkg::NUM_SYMBOLS - 1, '1);
        send_bar(smacd_pkg::NUM_SYMBOLS - 1, '0);
        set_windows(6, 3);
        send_bar(3, '0);
        send_bar(3, '1);
        set_windows(1, 127);
        send_bar(smacd_pkg::NUM_SYMBOLS - 1, '1);
        send_bar(smacd_pkg::NUM_SYMBOLS - 1, '0);
        set_windows(1, smacd_pkg::MAX_SLOW + 1);
        send_bar(3, '0);
        send_bar(3, '1);
    endtask

    // History survives a window change, so signals come back at once
    task automatic test_window_change();
        set_windows(1, 2);
        send_bar(smacd_pkg::NUM_SYMBOLS - 1, '1);
        send_bar(smacd_pkg::NUM_SYMBOLS - 1, '0);
        send_bar(3, '0);
    endtask

    // Receiver holds off while every bar crosses: the block must stall input
    task automatic test_output_backpressure();
        set_windows(1, 2);
        hold_request = 400;
        for (int i = 0; i < 14; i++)
            send_bar(5, (i % 2) ? 32'h0001_0000 : 32'h0000_8000);
        wait_results();
    endtask

    task automatic test_random_windows();
        int fast_list [9];
        int slow_list [9];
        int active;
        int base_sym;
        fast_list = '{1, 63, 2, 13, 1, 20, 3, 8, 0};
        slow_list = '{2, 64, 5, 34, 64, 21, 7, 21, 0};
        fast_list[8] = $urandom_range(1, smacd_pkg::MAX_SLOW - 1);
        slow_list[8] = $urandom_range(fast_list[8] + 1, smacd_pkg::MAX_SLOW);
        foreach (fast_list[p]) begin
            set_windows(fast_list[p], slow_list[p]);
            active   = (slow_list[p] > 32) ? 2 : $urandom_range(2, 6);
            base_sym = $urandom_range(0, smacd_pkg::NUM_SYMBOLS - 1);
            for (int i = 0; i < 120; i++) begin
                if (i % 40 == 0) begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                send_mixed_bar(base_sym, active);
            end
        end
    endtask

    initial begin : stimulus
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = smacd_pkg::CFG_FAST_WINDOW;
        cfg_wdata     = '0;
        aresetn       = 1'b0;
        clear_predictor();
        for (int s = 0; s < smacd_pkg::NUM_SYMBOLS; s++) begin
            walk_price[s] = $urandom();
            walk_left[s]  = 0;
            walk_up[s]    = 1'b0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_windows();
        test_minimal_windows();
        test_invalid_windows();
        test_window_change();
        test_output_backpressure();
        test_random_windows();
        wait_idle();

        $display("Sent %0d bars across %0d window settings, including invalid ones",
                 bars_taken, settings_used);
        $display("Checked %0d crossover words: %0d entries, %0d exits",
                 signals_seen, entries_seen, exits_seen);
        if (error_count == 0 && pending_signals.size() == 0) begin
            $display("sma_crossover_detector_tb passed");
        end else begin
            $display("sma_crossover_detector_tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #10_000_000;
        $display("%0t: timeout, %0d words still expected", $time, pending_signals.size());
        $display("sma_crossover_detector_tb failed");
        $finish;
    end

endmodule

/* sma_crossover_detector.f */
+incdir+rtl/core
rtl/core/smacd_pkg.sv
rtl/core/smacd_ctrl.sv
rtl/core/smacd_datapath.sv
rtl/core/sma_crossover_detector.sv
tb/sma_crossover_detector_tb.sv
